// ===== design/ntab_pkg.sv =====
// Shared types and constants of the neighbour table.
package ntab_pkg;

  localparam logic OP_BEACON = 1'b0;
  localparam logic OP_SWEEP  = 1'b1;

  localparam logic [4:0]  MAX_RESULTS   = 5'd16;
  localparam logic [15:0] TIMEOUT_RESET = 16'd10;

  localparam int ADDR_W = 8;
  localparam int TIME_W = 32;
  localparam int WORD_W = ADDR_W + TIME_W;

  typedef enum logic [2:0] {
    ST_REFRESHED = 3'd0,
    ST_INSERTED  = 3'd1,
    ST_FULL      = 3'd2,
    ST_EVICTED   = 3'd3,
    ST_IGNORED   = 3'd4
  } status_t;

  typedef struct packed {
    status_t     status;
    logic [3:0]  slot;
    logic [7:0]  addr;
    logic [4:0]  entry_count;
    logic        last;
  } res_t;

endpackage

// ===== design/ntab_mem.sv =====
// Table memory: one write port, one read port, registered read data.
module ntab_mem #(
  parameter  int DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [ntab_pkg::WORD_W-1:0] wdata,
  input  logic                        re,
  input  logic [AW-1:0]               raddr,
  output logic [ntab_pkg::WORD_W-1:0] rdata
);

  logic [ntab_pkg::WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/ntab_eng.sv =====
// Scan engine: walks the table memory for beacons and aging sweeps.
module ntab_eng #(
  parameter  int TABLE_ENTRIES = 16,
  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1,
  localparam int PW = $clog2(TABLE_ENTRIES + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        op,
  input  logic [7:0]                  src_addr,
  input  logic [31:0]                 now_s,
  input  logic [15:0]                 timeout,
  input  logic                        out_free,
  output logic                        push,
  output ntab_pkg::res_t              push_res,
  output logic                        mem_re,
  output logic [IW-1:0]               mem_raddr,
  input  logic [ntab_pkg::WORD_W-1:0] mem_rdata,
  output logic                        mem_we,
  output logic [IW-1:0]               mem_waddr,
  output logic [ntab_pkg::WORD_W-1:0] mem_wdata
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FIN, S_DRAIN} state_t;

  state_t             state;
  logic               op_q;
  logic [7:0]         src_q;
  logic [31:0]        now_q;
  logic [PW-1:0]      ptr;
  logic               e_vld;
  logic [IW-1:0]      e_idx;
  logic [TABLE_ENTRIES-1:0] vbits;
  logic [PW-1:0]      cnt;
  logic [4:0]         k;
  logic               pend_vld;
  ntab_pkg::res_t     pend;
  logic               match_f;
  logic [IW-1:0]      m_idx;
  logic               free_f;
  logic [IW-1:0]      f_idx;

  logic [7:0]         e_addr;
  logic [31:0]        e_time;
  logic [31:0]        age;
  logic               e_used;
  logic               is_sweep;
  logic               zero_src;
  logic               ptr_end;
  logic               live;
  logic               ev;
  logic               hit;
  logic               stall;
  logic               adv;
  logic               issue;
  logic               end_scan;
  logic [PW-1:0]      cnt_dec;
  logic [PW-1:0]      cnt_inc;
  logic [IW+3:0]      e_slot_x;
  logic [IW+3:0]      m_slot_x;
  logic [IW+3:0]      f_slot_x;
  logic [PW+4:0]      cnt_x;
  logic [PW+4:0]      dec_x;
  logic [PW+4:0]      inc_x;

  assign e_addr   = mem_rdata[ntab_pkg::WORD_W-1:ntab_pkg::TIME_W];
  assign e_time   = mem_rdata[ntab_pkg::TIME_W-1:0];
  assign age      = now_q - e_time;
  assign e_used   = vbits[e_idx];
  assign is_sweep = (op_q == ntab_pkg::OP_SWEEP);
  assign zero_src = (src_q == 8'd0);
  assign ptr_end  = (ptr == PW'(TABLE_ENTRIES));
  assign live     = e_vld && (k < ntab_pkg::MAX_RESULTS);
  assign ev       = is_sweep && live && e_used && (age >= {16'd0, timeout});
  assign hit      = !is_sweep && e_vld && e_used && (e_addr == src_q);
  assign stall    = ev && pend_vld && !out_free;
  assign adv      = (state == S_SCAN) && !stall;
  assign issue    = adv && !ptr_end;
  assign end_scan = (!e_vld && ptr_end) || (is_sweep && (k == ntab_pkg::MAX_RESULTS));
  assign cnt_dec  = cnt - PW'(1);
  assign cnt_inc  = cnt + PW'(1);

  assign e_slot_x = {4'd0, e_idx};
  assign m_slot_x = {4'd0, m_idx};
  assign f_slot_x = {4'd0, f_idx};
  assign cnt_x    = {5'd0, cnt};
  assign dec_x    = {5'd0, cnt_dec};
  assign inc_x    = {5'd0, cnt_inc};

  assign in_ready  = (state == S_IDLE);
  assign mem_re    = issue;
  assign mem_raddr = ptr[IW-1:0];
  assign mem_we    = (state == S_FIN) && out_free && !zero_src && (match_f || free_f);
  assign mem_waddr = match_f ? m_idx : f_idx;
  assign mem_wdata = {src_q, now_q};

  always_comb begin
    push     = 1'b0;
    push_res = pend;
    case (state)
      S_SCAN: begin
        push = ev && pend_vld;
      end
      S_FIN: begin
        push             = 1'b1;
        push_res.last    = 1'b1;
        push_res.addr    = src_q;
        push_res.entry_count = cnt_x[4:0];
        if (zero_src) begin
          push_res.status = ntab_pkg::ST_IGNORED;
          push_res.slot   = 4'd0;
          push_res.addr   = 8'd0;
        end else if (match_f) begin
          push_res.status = ntab_pkg::ST_REFRESHED;
          push_res.slot   = m_slot_x[3:0];
        end else if (free_f) begin
          push_res.status      = ntab_pkg::ST_INSERTED;
          push_res.slot        = f_slot_x[3:0];
          push_res.entry_count = inc_x[4:0];
        end else begin
          push_res.status = ntab_pkg::ST_FULL;
          push_res.slot   = 4'd0;
        end
      end
      S_DRAIN: begin
        push          = pend_vld;
        push_res.last = 1'b1;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      vbits    <= '0;
      cnt      <= '0;
      pend_vld <= 1'b0;
      e_vld    <= 1'b0;
      k        <= 5'd0;
      match_f  <= 1'b0;
      free_f   <= 1'b0;
      ptr      <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_q    <= op;
            src_q   <= src_addr;
            now_q   <= now_s;
            ptr     <= '0;
            e_vld   <= 1'b0;
            k       <= 5'd0;
            match_f <= 1'b0;
            free_f  <= 1'b0;
            if (op == ntab_pkg::OP_BEACON && src_addr == 8'd0) begin
              state <= S_FIN;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (adv) begin
            e_vld <= issue;
            e_idx <= ptr[IW-1:0];
            if (issue) begin
              ptr <= ptr + PW'(1);
            end
          end
          if (!is_sweep) begin
            if (hit) begin
              match_f <= 1'b1;
              m_idx   <= e_idx;
              state   <= S_FIN;
            end else if (e_vld && !e_used && !free_f) begin
              free_f <= 1'b1;
              f_idx  <= e_idx;
            end
            if (end_scan) begin
              state <= S_FIN;
            end
          end else begin
            if (ev && !stall) begin
              vbits[e_idx]     <= 1'b0;
              cnt              <= cnt_dec;
              k                <= k + 5'd1;
              pend_vld         <= 1'b1;
              pend.status      <= ntab_pkg::ST_EVICTED;
              pend.slot        <= e_slot_x[3:0];
              pend.addr        <= e_addr;
              pend.entry_count <= dec_x[4:0];
              pend.last        <= 1'b0;
            end
            if (end_scan) begin
              state <= S_DRAIN;
            end
          end
        end
        S_FIN: begin
          if (out_free) begin
            if (!zero_src && !match_f && free_f) begin
              vbits[f_idx] <= 1'b1;
              cnt          <= cnt_inc;
            end
            state <= S_IDLE;
          end
        end
        S_DRAIN: begin
          if (!pend_vld) begin
            state <= S_IDLE;
          end else if (out_free) begin
            pend_vld <= 1'b0;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== design/neighbor_table_with_aging.sv =====
// Top level of the neighbour address table with aging.
//
// Input channel (in_valid/in_ready): op 0 is a beacon from src_addr at time
// now_s, op 1 is an aging sweep at time now_s. One request is worked at a time.
// A beacon scans the table memory one slot per cycle, stopping at a match,
// and gives one result; a beacon from address 0 gives it without a scan.
// A sweep scans every slot, one per cycle while the scan is not held, and
// stops early once MAX_RESULTS (16) entries are evicted. It gives one result
// per evicted entry, the final one marked by last; a sweep with nothing
// expired gives no result. Its final result is loaded from the drain state
// after the scan, and the next request is taken once the engine is idle.
// Output channel (out_valid/out_ready): a result register; the scan holds
// while a result waits there and a further eviction needs to be sent.
// Configuration channel (cfg_valid/cfg_ready): writes aging_timeout_s; it is
// always ready, but it must be written only while the table is idle; the
// block itself does not enforce this. Reset clears every slot at once
// (per-slot valid flags, no clearing pass) and sets the timeout to 10 seconds.
module neighbor_table_with_aging #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        op,
  input  logic [7:0]  src_addr,
  input  logic [31:0] now_s,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [3:0]  slot,
  output logic [7:0]  addr,
  output logic [4:0]  entry_count,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] aging_timeout_s
);

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  logic [15:0]                 timeout;
  logic                        out_free;
  logic                        push;
  ntab_pkg::res_t              push_res;
  ntab_pkg::res_t              res_q;
  logic                        mem_re;
  logic [IW-1:0]               mem_raddr;
  logic [ntab_pkg::WORD_W-1:0] mem_rdata;
  logic                        mem_we;
  logic [IW-1:0]               mem_waddr;
  logic [ntab_pkg::WORD_W-1:0] mem_wdata;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout <= ntab_pkg::TIMEOUT_RESET;
    end else if (cfg_valid) begin
      timeout <= aging_timeout_s;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (push && out_free) begin
      res_q <= push_res;
    end
  end

  assign status      = res_q.status;
  assign slot        = res_q.slot;
  assign addr        = res_q.addr;
  assign entry_count = res_q.entry_count;
  assign last        = res_q.last;

  ntab_mem #(
    .DEPTH(TABLE_ENTRIES)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  ntab_eng #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_eng (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .op       (op),
    .src_addr (src_addr),
    .now_s    (now_s),
    .timeout  (timeout),
    .out_free (out_free),
    .push     (push),
    .push_res (push_res),
    .mem_re   (mem_re),
    .mem_raddr(mem_raddr),
    .mem_rdata(mem_rdata),
    .mem_we   (mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata)
  );

endmodule

// ===== design/ntab_chk.sv =====
// Port-level checker for the neighbour table, bound to the top level.
module ntab_chk (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] status,
  input logic [3:0] slot,
  input logic [7:0] addr,
  input logic [4:0] entry_count,
  input logic       last
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable({status, slot, addr, entry_count, last}))
    else $error("result changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("new request taken while one is in work");

  a_beacon_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ntab_pkg::ST_REFRESHED || status == ntab_pkg::ST_INSERTED ||
                  status == ntab_pkg::ST_FULL || status == ntab_pkg::ST_IGNORED) |-> last)
    else $error("beacon result without last");

  a_ignored_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ntab_pkg::ST_IGNORED |-> slot == 4'd0 && addr == 8'd0)
    else $error("ignored beacon reports a slot or address");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= ntab_pkg::ST_IGNORED)
    else $error("unknown status code");

endmodule

bind neighbor_table_with_aging ntab_chk u_chk (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .status     (status),
  .slot       (slot),
  .addr       (addr),
  .entry_count(entry_count),
  .last       (last)
);
